[hdl/qgsv_pkg.sv]
package qgsv_pkg;

	// defaults for the top-level parameters
	localparam int QUBITS_DEF          = 10;
	localparam int MAX_GATE_QUBITS_DEF = 2;
	localparam int PART_WIDTH_DEF      = 32;

	// fixed field widths on the ports
	localparam int IO_PART_W = 32;
	localparam int OP_W      = 2;
	localparam int INDEX_W   = 10;
	localparam int START_W   = 4;
	localparam int GW_W      = 2;
	localparam int QC_W      = 4;

	localparam logic [QC_W-1:0] QUBIT_COUNT_RST = 4'd10;

	// command fields sized for the largest parameter values
	localparam int ADDR_MAX_W     = 20;
	localparam int MAT_ADDR_MAX_W = 6;
	localparam int K_MAX_W        = 3;

	typedef enum logic [OP_W-1:0] {
		OP_WR_AMP = 2'd0,
		OP_RD_AMP = 2'd1,
		OP_WR_MAT = 2'd2,
		OP_APPLY  = 2'd3
	} op_t;

	typedef struct packed {
		logic                      latch;
		logic                      amp_rd;
		logic                      amp_wr;
		logic                      wr_acc;
		logic [ADDR_MAX_W-1:0]     amp_addr;
		logic                      cap;
		logic [K_MAX_W-1:0]        cap_k;
		logic                      mat_rd;
		logic                      mat_wr;
		logic [MAT_ADDR_MAX_W-1:0] mat_addr;
		logic                      mac;
		logic                      mac_first;
		logic [K_MAX_W-1:0]        mac_c;
		logic                      res_load;
		logic                      res_rd;
		logic                      res_status;
	} qgsv_cmd_t;

endpackage

[hdl/qgsv_if.sv]
interface qgsv_item_if;
	import qgsv_pkg::*;
	logic                       valid;
	logic                       ready;
	logic [OP_W-1:0]            op;
	logic [INDEX_W-1:0]         index;
	logic signed [IO_PART_W-1:0] value_re;
	logic signed [IO_PART_W-1:0] value_im;
	logic [START_W-1:0]         first_qubit;
	logic [GW_W-1:0]            gate_width;

	modport source (output valid, op, index, value_re, value_im, first_qubit, gate_width,
		input ready);
	modport sink (input valid, op, index, value_re, value_im, first_qubit, gate_width,
		output ready);
endinterface

interface qgsv_result_if;
	import qgsv_pkg::*;
	logic                        valid;
	logic                        ready;
	logic signed [IO_PART_W-1:0] read_re;
	logic signed [IO_PART_W-1:0] read_im;
	logic                        status;

	modport source (output valid, read_re, read_im, status, input ready);
	modport sink (input valid, read_re, read_im, status, output ready);
endinterface

[hdl/quantum_gate_state_vector_apply_core.sv]
// Channel   Dir  Transfer moves
// item      in   op, index, value_re, value_im, first_qubit, gate_width
// result    out  read_re, read_im, status (one per item)
// cfg       in   qubit_count write (cfg_we, cfg_wdata)
//
// Amplitude and matrix reads/writes pass one execute state to the result.
// Apply with S = 2^gate_width walks 2^(n-w) groups; per group it reads S
// amplitudes, then per row does S multiply-accumulates, drains, writes back,
// serialized by the single amplitude memory port and the one complex MAC.
// Reset (arst_n) clears control state; memory contents stay undefined.
// A new item transfers while the previous result still waits on result.ready.

module quantum_gate_state_vector_apply_core #(
	parameter int QUBITS          = qgsv_pkg::QUBITS_DEF,
	parameter int MAX_GATE_QUBITS = qgsv_pkg::MAX_GATE_QUBITS_DEF,
	parameter int PART_WIDTH      = qgsv_pkg::PART_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	qgsv_item_if.sink                 item,
	qgsv_result_if.source             result,
	input  logic                      cfg_we,
	input  logic [qgsv_pkg::QC_W-1:0] cfg_wdata
);
	import qgsv_pkg::*;

	qgsv_cmd_t cmd;   // controller -> datapath commands
	logic      res_valid;

	// controller: decode, qubit_count register, group/row/column sequencing
	qgsv_ctrl #(
		.QUBITS          (QUBITS),
		.MAX_GATE_QUBITS (MAX_GATE_QUBITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.res_ready (result.ready),
		.res_valid (res_valid),
		.cmd       (cmd)
	);

	// datapath: memories, complex MAC, result register
	qgsv_dp #(
		.QUBITS          (QUBITS),
		.MAX_GATE_QUBITS (MAX_GATE_QUBITS),
		.PART_WIDTH      (PART_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.value_re (item.value_re),
		.value_im (item.value_im),
		.read_re  (result.read_re),
		.read_im  (result.read_im),
		.status   (result.status)
	);

	assign result.valid = res_valid;

endmodule

[hdl/qgsv_ctrl.sv]
module qgsv_ctrl #(
	parameter int QUBITS          = qgsv_pkg::QUBITS_DEF,
	parameter int MAX_GATE_QUBITS = qgsv_pkg::MAX_GATE_QUBITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	qgsv_item_if.sink                  item,
	input  logic                       cfg_we,
	input  logic [qgsv_pkg::QC_W-1:0]  cfg_wdata,
	input  logic                       res_ready,
	output logic                       res_valid,
	output qgsv_pkg::qgsv_cmd_t        cmd
);
	import qgsv_pkg::*;

	localparam int AW = QUBITS;
	localparam int M  = MAX_GATE_QUBITS;
	localparam int SW = $clog2(QUBITS + 16) + 1;

	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_AP_RD, S_AP_MAC, S_AP_DRAIN, S_AP_WB, S_DONE
	} state_t;

	state_t            state_q;
	logic [QC_W-1:0]   qc_q;
	op_t               op_q;
	logic [AW-1:0]     idx_q;
	logic [MAT_ADDR_MAX_W-1:0] midx_q;
	logic [SW-1:0]     low_q;
	logic [SW-1:0]     w_q;
	logic [AW-1:0]     grp_q;
	logic [AW-1:0]     grp_end_q;
	logic [M-1:0]      k_q;
	logic [M-1:0]      r_q;
	logic [M-1:0]      last_q;
	logic              drain_q;
	logic              status_q;
	logic              res_valid_q;

	logic [SW-1:0] qc_ext, n, st_ext, gw_ext, low_new, grp_bits;
	logic [31:0]   idx32;
	logic          bad_gate, amp_oob, mat_oob, accept, res_free;
	logic [AW-1:0] lo_mask, base_j, addr_k, addr_r;
	op_t           op_in;

	always_comb begin
		qc_ext = SW'(qc_q);
		if (qc_q == '0) begin
			n = SW'(1);
		end else if (qc_ext > SW'(QUBITS)) begin
			n = SW'(QUBITS);
		end else begin
			n = qc_ext;
		end
		st_ext   = SW'(item.first_qubit);
		gw_ext   = SW'(item.gate_width);
		bad_gate = (gw_ext == '0) || (gw_ext > SW'(M)) || (st_ext + gw_ext > n);
		low_new  = n - st_ext - gw_ext;
		grp_bits = n - gw_ext;
		idx32    = 32'(item.index);
		amp_oob  = (idx32 >> n) != 32'd0;
		mat_oob  = (idx32 >> (2 * M)) != 32'd0;
		op_in    = op_t'(item.op);
		accept   = item.valid && item.ready;
		res_free = !res_valid_q || res_ready;
	end

	// group base: insert w zero bits at the gate position of the group count
	always_comb begin
		lo_mask = ~({AW{1'b1}} << low_q);
		base_j  = ((grp_q >> low_q) << (low_q + w_q)) | (grp_q & lo_mask);
		addr_k  = base_j | (AW'(k_q) << low_q);
		addr_r  = base_j | (AW'(r_q) << low_q);
	end

	assign item.ready = (state_q == S_IDLE);
	assign res_valid  = res_valid_q;

	always_comb begin
		cmd       = '0;
		cmd.latch = accept;
		unique case (state_q)
			S_IDLE: begin
			end
			S_EXEC: begin
				cmd.amp_addr = ADDR_MAX_W'(idx_q);
				cmd.mat_addr = midx_q;
				cmd.amp_wr   = (op_q == OP_WR_AMP) && !status_q;
				cmd.amp_rd   = (op_q == OP_RD_AMP);
				cmd.mat_wr   = (op_q == OP_WR_MAT) && !status_q;
			end
			S_AP_RD: begin
				cmd.amp_rd   = 1'b1;
				cmd.amp_addr = ADDR_MAX_W'(addr_k);
				cmd.cap      = 1'b1;
				cmd.cap_k    = K_MAX_W'(k_q);
			end
			S_AP_MAC: begin
				cmd.mat_rd    = 1'b1;
				cmd.mat_addr  = MAT_ADDR_MAX_W'({r_q, k_q});
				cmd.mac       = 1'b1;
				cmd.mac_first = (k_q == '0);
				cmd.mac_c     = K_MAX_W'(k_q);
			end
			S_AP_DRAIN: begin
			end
			S_AP_WB: begin
				cmd.amp_wr   = 1'b1;
				cmd.wr_acc   = 1'b1;
				cmd.amp_addr = ADDR_MAX_W'(addr_r);
			end
			S_DONE: begin
				cmd.res_load   = res_free;
				cmd.res_rd     = (op_q == OP_RD_AMP) && !status_q;
				cmd.res_status = status_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			qc_q        <= QUBIT_COUNT_RST;
			res_valid_q <= 1'b0;
			op_q        <= OP_WR_AMP;
			idx_q       <= '0;
			midx_q      <= '0;
			low_q       <= '0;
			w_q         <= '0;
			grp_q       <= '0;
			grp_end_q   <= '0;
			k_q         <= '0;
			r_q         <= '0;
			last_q      <= '0;
			drain_q     <= 1'b0;
			status_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				qc_q <= cfg_wdata;
			end
			// a new result loads when none is held or as the old one leaves
			if (state_q == S_DONE && res_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q      <= op_in;
						idx_q     <= idx32[AW-1:0];
						midx_q    <= MAT_ADDR_MAX_W'(idx32[2*M-1:0]);
						low_q     <= low_new;
						w_q       <= gw_ext;
						grp_q     <= '0;
						grp_end_q <= {AW{1'b1}} >> (SW'(AW) - grp_bits);
						last_q    <= M'((32'd1 << gw_ext) - 32'd1);
						k_q       <= '0;
						r_q       <= '0;
						unique case (op_in)
							OP_WR_AMP, OP_RD_AMP: begin
								status_q <= amp_oob;
								state_q  <= S_EXEC;
							end
							OP_WR_MAT: begin
								status_q <= mat_oob;
								state_q  <= S_EXEC;
							end
							default: begin
								status_q <= bad_gate;
								state_q  <= bad_gate ? S_DONE : S_AP_RD;
							end
						endcase
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
				end
				S_AP_RD: begin
					if (k_q == last_q) begin
						k_q     <= '0;
						r_q     <= '0;
						state_q <= S_AP_MAC;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_AP_MAC: begin
					if (k_q == last_q) begin
						k_q     <= '0;
						drain_q <= 1'b0;
						state_q <= S_AP_DRAIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_AP_DRAIN: begin
					if (drain_q) begin
						state_q <= S_AP_WB;
					end else begin
						drain_q <= 1'b1;
					end
				end
				S_AP_WB: begin
					if (r_q == last_q) begin
						if (grp_q == grp_end_q) begin
							state_q <= S_DONE;
						end else begin
							grp_q   <= grp_q + 1'b1;
							k_q     <= '0;
							state_q <= S_AP_RD;
						end
					end else begin
						r_q     <= r_q + 1'b1;
						state_q <= S_AP_MAC;
					end
				end
				S_DONE: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[hdl/qgsv_dp.sv]
module qgsv_dp #(
	parameter int QUBITS          = qgsv_pkg::QUBITS_DEF,
	parameter int MAX_GATE_QUBITS = qgsv_pkg::MAX_GATE_QUBITS_DEF,
	parameter int PART_WIDTH      = qgsv_pkg::PART_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  qgsv_pkg::qgsv_cmd_t                   cmd,
	input  logic signed [qgsv_pkg::IO_PART_W-1:0] value_re,
	input  logic signed [qgsv_pkg::IO_PART_W-1:0] value_im,
	output logic signed [qgsv_pkg::IO_PART_W-1:0] read_re,
	output logic signed [qgsv_pkg::IO_PART_W-1:0] read_im,
	output logic                                  status
);
	import qgsv_pkg::*;

	localparam int AW   = QUBITS;
	localparam int M    = MAX_GATE_QUBITS;
	localparam int D    = 1 << M;
	localparam int MAW  = 2 * M;
	localparam int P    = PART_WIDTH;
	localparam int F    = P - 2;
	localparam int PW2  = 2 * P + 1;
	localparam int RW   = P + 2;
	localparam int TW   = P + 3;
	localparam int ACCW = P + 4 + M;

	localparam logic signed [63:0] PMAX = (64'sd1 <<< (P - 1)) - 64'sd1;
	localparam logic signed [63:0] PMIN = -PMAX - 64'sd1;
	localparam logic signed [PW2-1:0] HALF = PW2'(64'sd1 <<< (F - 1));

	function automatic logic signed [P-1:0] sat_part(input logic signed [63:0] v);
		if (v > PMAX) begin
			return P'(PMAX);
		end else if (v < PMIN) begin
			return P'(PMIN);
		end
		return P'(v);
	endfunction

	logic [2*P-1:0] amp_mem [2**AW];
	logic [2*P-1:0] mat_mem [D*D];

	logic signed [P-1:0] val_re_q, val_im_q;
	logic signed [P-1:0] rd_re_q, rd_im_q;
	logic signed [P-1:0] mat_re_q, mat_im_q;
	logic signed [P-1:0] t_re_q [D];
	logic signed [P-1:0] t_im_q [D];

	logic               cap_s1, mac_s1, first_s1, mac_s2, first_s2;
	logic [M-1:0]       cap_k_s1, c_s1;
	logic signed [2*P-1:0] p0_s2, p1_s2, p2_s2, p3_s2;
	logic signed [ACCW-1:0] acc_re_q, acc_im_q;
	logic signed [IO_PART_W-1:0] res_re_q, res_im_q;
	logic               res_status_q;

	logic [AW-1:0]  aaddr;
	logic [MAW-1:0] maddr;
	logic [2*P-1:0] wr_data;
	logic signed [RW-1:0] r0, r1, r2, r3;
	logic signed [TW-1:0] term_re, term_im;

	always_comb begin
		aaddr   = cmd.amp_addr[AW-1:0];
		maddr   = cmd.mat_addr[MAW-1:0];
		wr_data = cmd.wr_acc
			? {sat_part(64'(acc_re_q)), sat_part(64'(acc_im_q))}
			: {val_re_q, val_im_q};
		// round to nearest, ties up: add half an LSB, then floor shift
		r0 = RW'((PW2'(p0_s2) + HALF) >>> F);
		r1 = RW'((PW2'(p1_s2) + HALF) >>> F);
		r2 = RW'((PW2'(p2_s2) + HALF) >>> F);
		r3 = RW'((PW2'(p3_s2) + HALF) >>> F);
		term_re = TW'(r0) - TW'(r1);
		term_im = TW'(r2) + TW'(r3);
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			val_re_q <= sat_part(64'(value_re));
			val_im_q <= sat_part(64'(value_im));
		end
		if (cmd.amp_wr) begin
			amp_mem[aaddr] <= wr_data;
		end
		if (cmd.amp_rd) begin
			{rd_re_q, rd_im_q} <= amp_mem[aaddr];
		end
		if (cmd.mat_wr) begin
			mat_mem[maddr] <= {val_re_q, val_im_q};
		end
		if (cmd.mat_rd) begin
			{mat_re_q, mat_im_q} <= mat_mem[maddr];
		end
		cap_k_s1 <= cmd.cap_k[M-1:0];
		c_s1     <= cmd.mac_c[M-1:0];
		first_s1 <= cmd.mac_first;
		first_s2 <= first_s1;
		if (cap_s1) begin
			t_re_q[cap_k_s1] <= rd_re_q;
			t_im_q[cap_k_s1] <= rd_im_q;
		end
		p0_s2 <= mat_re_q * t_re_q[c_s1];
		p1_s2 <= mat_im_q * t_im_q[c_s1];
		p2_s2 <= mat_re_q * t_im_q[c_s1];
		p3_s2 <= mat_im_q * t_re_q[c_s1];
		if (mac_s2) begin
			acc_re_q <= (first_s2 ? ACCW'(0) : acc_re_q) + ACCW'(term_re);
			acc_im_q <= (first_s2 ? ACCW'(0) : acc_im_q) + ACCW'(term_im);
		end
		if (cmd.res_load) begin
			res_re_q     <= cmd.res_rd ? IO_PART_W'(rd_re_q) : '0;
			res_im_q     <= cmd.res_rd ? IO_PART_W'(rd_im_q) : '0;
			res_status_q <= cmd.res_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_s1 <= 1'b0;
			mac_s1 <= 1'b0;
			mac_s2 <= 1'b0;
		end else begin
			cap_s1 <= cmd.cap;
			mac_s1 <= cmd.mac;
			mac_s2 <= mac_s1;
		end
	end

	assign read_re = res_re_q;
	assign read_im = res_im_q;
	assign status  = res_status_q;

endmodule

[sim/quantum_gate_state_vector_apply_core_test.sv]
`timescale 1ns / 1ps

module quantum_gate_state_vector_apply_core_test;
	import qgsv_pkg::*;

	localparam int STORE_N = 1 << QUBITS_DEF;
	localparam int MAT_D   = 1 << MAX_GATE_QUBITS_DEF;
	localparam int MAT_N   = MAT_D * MAT_D;
	localparam int WDOG_LIMIT = 200000;

	typedef struct {
		logic signed [31:0] re;
		logic signed [31:0] im;
		logic               status;
	} amp_result_t;

	// Shadow of the state vector and gate matrix; computes the expected result
	// of every accepted transfer and checks results in order.
	class gate_scoreboard;
		int                 errors;
		int                 checked;
		int                 applies;
		int                 flagged;
		logic signed [31:0] amp_re [STORE_N];
		logic signed [31:0] amp_im [STORE_N];
		logic signed [31:0] mat_re [MAT_N];
		logic signed [31:0] mat_im [MAT_N];
		bit                 written [STORE_N];
		logic [QC_W-1:0]    qubit_count;
		amp_result_t        expected_q [$];

		function new();
			errors = 0;
			checked = 0;
			applies = 0;
			flagged = 0;
			qubit_count = QUBIT_COUNT_RST;
			foreach (written[i]) written[i] = 0;
		endfunction

		function int active_qubits();
			if (qubit_count < 1) return 1;
			if (qubit_count > QUBITS_DEF) return QUBITS_DEF;
			return qubit_count;
		endfunction

		// true when every amplitude in use has a known value
		function bit vector_known();
			for (int i = 0; i < (1 << active_qubits()); i++)
				if (!written[i]) return 0;
			return 1;
		endfunction

		// product rounded to nearest, ties up, back to Q2.30
		function longint round_mul(logic signed [31:0] a, logic signed [31:0] b);
			longint p;
			p = longint'(a) * longint'(b);
			return (p + (longint'(1) << 29)) >>> 30;
		endfunction

		function logic signed [31:0] clamp(longint v);
			if (v > 64'sd2147483647) return 32'sh7fffffff;
			if (v < -64'sd2147483648) return 32'sh80000000;
			return v[31:0];
		endfunction

		function void apply_gate(int n, int start, int w);
			int                 low;
			int                 step2;
			int                 step1;
			int                 size;
			int                 m;
			longint             sre;
			longint             sim;
			logic signed [31:0] tre [MAT_D];
			logic signed [31:0] tim [MAT_D];
			low = n - start - w;
			step2 = 1 << low;
			step1 = 1 << (low + w);
			size = 1 << w;
			for (int base = 0; base < (1 << n); base += step1)
				for (int j = base; j < base + step2; j++) begin
					for (int r = 0; r < size; r++) begin
						tre[r] = amp_re[j + r * step2];
						tim[r] = amp_im[j + r * step2];
					end
					for (int r = 0; r < size; r++) begin
						sre = 0;
						sim = 0;
						for (int c = 0; c < size; c++) begin
							m = r * MAT_D + c;
							sre += round_mul(mat_re[m], tre[c]) - round_mul(mat_im[m], tim[c]);
							sim += round_mul(mat_re[m], tim[c]) + round_mul(mat_im[m], tre[c]);
						end
						amp_re[j + r * step2] = clamp(sre);
						amp_im[j + r * step2] = clamp(sim);
					end
				end
		endfunction

		function void note_item(op_t op, int idx, logic signed [31:0] vre,
				logic signed [31:0] vim, int start, int w);
			amp_result_t e;
			int          n;
			n = active_qubits();
			e.re = 0;
			e.im = 0;
			e.status = 0;
			case (op)
				OP_WR_AMP, OP_RD_AMP: begin
					if (idx >= (1 << n)) begin
						e.status = 1;
					end else if (op == OP_WR_AMP) begin
						amp_re[idx] = vre;
						amp_im[idx] = vim;
						written[idx] = 1;
					end else begin
						e.re = amp_re[idx];
						e.im = amp_im[idx];
					end
				end
				OP_WR_MAT: begin
					if (idx >= MAT_N) begin
						e.status = 1;
					end else begin
						mat_re[idx] = vre;
						mat_im[idx] = vim;
					end
				end
				default: begin
					if (w == 0 || w > MAX_GATE_QUBITS_DEF || start + w > n) begin
						e.status = 1;
					end else begin
						apply_gate(n, start, w);
						applies++;
					end
				end
			endcase
			if (e.status) flagged++;
			expected_q.push_back(e);
		endfunction

		task report(string field, longint exp_v, longint got_v);
			$display("mismatch on result %0d: %s expected %0h got %0h",
				checked, field, exp_v, got_v);
			errors++;
		endtask

		task check_result(logic signed [31:0] re, logic signed [31:0] im,
				logic st);
			amp_result_t e;
			if (expected_q.size() == 0) begin
				report("unexpected result, status", 0, st);
				return;
			end
			e = expected_q.pop_front();
			if (re !== e.re) report("read_re", e.re, re);
			if (im !== e.im) report("read_im", e.im, im);
			if (st !== e.status) report("status", e.status, st);
			checked++;
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we;
	logic [QC_W-1:0] cfg_wdata;

	qgsv_item_if   item_if ();
	qgsv_result_if res_if ();

	quantum_gate_state_vector_apply_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_if),
		.result    (res_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	gate_scoreboard sb = new();

	// idle percentages for the current phase
	int send_idle_pct = 0;
	int stall_pct = 0;
	int wdog = 0;
	int sent = 0;

	always #4 clk = ~clk;

	// result side: check every transfer, stall at random
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			sb.check_result(res_if.read_re, res_if.read_im, res_if.status);
		res_if.ready <= ($urandom_range(99) >= stall_pct);
	end

	// watchdog: cycles with no transfer on either side
	always @(posedge clk) begin
		if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready))
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WDOG_LIMIT) begin
			$display("watchdog expired, %0d results outstanding", sb.expected_q.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Drive one item; valid stays high into the next call unless a gap is rolled.
	task automatic send_item(op_t op, int idx, logic signed [31:0] vre,
			logic signed [31:0] vim, int start, int w);
		int gap;
		gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(4, 1) : 0;
		if (gap > 0) begin
			item_if.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		item_if.valid       <= 1;
		item_if.op          <= op;
		item_if.index       <= idx[INDEX_W-1:0];
		item_if.value_re    <= vre;
		item_if.value_im    <= vim;
		item_if.first_qubit <= start[START_W-1:0];
		item_if.gate_width  <= w[GW_W-1:0];
		do @(posedge clk); while (!item_if.ready);
		sb.note_item(op, idx, vre, vim, start, w);
		sent++;
	endtask

	task automatic drain();
		item_if.valid <= 0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
	endtask

	// Register writes only with the block idle: every result back, then a
	// short settle since the block retires its last item before going idle.
	task automatic write_qubit_count(int qc);
		drain();
		repeat (10) @(posedge clk);
		cfg_we    <= 1;
		cfg_wdata <= qc[QC_W-1:0];
		@(posedge clk);
		cfg_we    <= 0;
		sb.qubit_count = qc[QC_W-1:0];
	endtask

	// Mix of tiny, near-unity and full-range parts so saturation is hit sometimes.
	function automatic logic signed [31:0] rand_part();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(2 * (1 << 28))) - (1 << 28);
			2: return ($urandom_range(1) ? 32'sh40000000 : 32'shc0000000);
			default: return $signed($urandom_range(2 * (1 << 24))) - (1 << 24);
		endcase
	endfunction

	// write any amplitude in use that still has no value
	task automatic fill_vector();
		for (int i = 0; i < (1 << sb.active_qubits()); i++)
			if (!sb.written[i]) send_item(OP_WR_AMP, i, rand_part(), rand_part(), 0, 0);
	endtask

	task automatic random_items(int count);
		int    n;
		int    idx;
		int    w;
		bit    full;
		op_t   op;
		for (int k = 0; k < count; k++) begin
			n = sb.active_qubits();
			full = sb.vector_known();
			op = op_t'($urandom_range(3));
			case (op)
				OP_WR_AMP: begin
					idx = $urandom_range(STORE_N - 1);
					send_item(op, idx, rand_part(), rand_part(), $urandom_range(15),
						$urandom_range(3));
				end
				OP_RD_AMP: begin
					idx = $urandom_range(STORE_N - 1);
					// in range but never written: read a known one instead
					if (idx < (1 << n) && !sb.written[idx]) idx = $urandom_range(7);
					send_item(op, idx, $urandom, $urandom, $urandom_range(15),
						$urandom_range(3));
				end
				OP_WR_MAT: begin
					idx = ($urandom_range(9) == 0) ? $urandom_range(STORE_N - 1, MAT_N)
						: $urandom_range(MAT_N - 1);
					send_item(op, idx, rand_part(), rand_part(), 0, 0);
				end
				default: begin
					// mostly legal placements; legal ones only when the vector is known
					if (full && $urandom_range(4) != 0) begin
						w = $urandom_range(MAX_GATE_QUBITS_DEF, 1);
						if (w > n) w = n;
						send_item(op, $urandom_range(STORE_N - 1), $urandom, $urandom,
							$urandom_range(n - w), w);
					end else begin
						case ($urandom_range(2))
							0: send_item(op, 0, 0, 0, $urandom_range(15), 0);
							1: send_item(op, 0, 0, 0, $urandom_range(15), 3);
							default: send_item(op, 0, 0, 0, $urandom_range(15, n), 1);
						endcase
					end
				end
			endcase
		end
	endtask

	int phase_qc [8] = '{5, 0, 6, 15, 2, 4, 1, 3};

	initial begin
		item_if.valid       <= 0;
		item_if.op          <= OP_WR_AMP;
		item_if.index       <= 0;
		item_if.value_re    <= 0;
		item_if.value_im    <= 0;
		item_if.first_qubit <= 0;
		item_if.gate_width  <= 0;
		cfg_we              <= 0;
		cfg_wdata           <= 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: reset count (10 qubits) for edge indices, then a 3 qubit vector.
		send_item(OP_WR_AMP, STORE_N - 1, 32'sh7fffffff, 32'sh80000000, 0, 0);
		send_item(OP_RD_AMP, STORE_N - 1, 0, 0, 0, 0);
		send_item(OP_APPLY, 0, 0, 0, 9, 2);   // start + width past the last qubit
		write_qubit_count(3);
		send_item(OP_WR_AMP, 8, 1, 1, 0, 0);  // index out of range
		send_item(OP_RD_AMP, STORE_N - 1, 0, 0, 0, 0);
		for (int i = 0; i < 8; i++)
			send_item(OP_WR_AMP, i, (i[0] ? 32'sh80000000 : 32'sh7fffffff),
				(i[1] ? 32'sh40000000 : -32'sh40000000), 0, 0);
		for (int i = 0; i < MAT_N; i++)
			send_item(OP_WR_MAT, i, ((i % 5) == 0 ? 32'sh40000000 : 32'sh7fffffff),
				(i[0] ? 32'sh80000000 : 32'sh00000001), 0, 0);
		send_item(OP_WR_MAT, MAT_N, 0, 0, 0, 0);
		send_item(OP_APPLY, 0, 0, 0, 0, 0);   // zero width
		send_item(OP_APPLY, 0, 0, 0, 0, 3);   // wider than the gate matrix
		send_item(OP_APPLY, 0, 0, 0, 2, 1);
		send_item(OP_APPLY, 0, 0, 0, 1, 2);
		send_item(OP_RD_AMP, 5, 0, 0, 0, 0);

		// pressure: hold off until every expected result has come back
		drain();
		send_item(OP_RD_AMP, 0, 0, 0, 0, 0);

		foreach (phase_qc[p]) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 66; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 66; end
				default: begin send_idle_pct = 14; stall_pct = 14; end
			endcase
			write_qubit_count(phase_qc[p]);
			if (sb.active_qubits() <= 6) fill_vector();
			random_items(phase_qc[p] == 15 ? 40 : 64);
		end

		drain();
		repeat (50) @(posedge clk);
		$display("%0d items sent, %0d results checked, %0d gates applied, %0d flagged",
			sent, sb.checked, sb.applies, sb.flagged);
		$display("qubit counts 0..15 incl. extremes, four idle/stall mixes");
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
